// ----- rtl/dcf_pkg.sv -----
// dcf_pkg: shared constants, types and control structs of the decimate and crossfade core
// no dependencies; used by dcf_lane, dcf_hist and the top level
package dcf_pkg;

    // raw samples summed into one output sample
    localparam int DECIMATION  = 2;
    // outputs blended at a segment start, and depth of the history ring
    localparam int FADE_LENGTH = 31;
    localparam int FADE_DIV    = FADE_LENGTH + 1;

    // sample widths
    localparam int RAW_W  = 16;
    localparam int OUT_W  = 16;
    // a clamped and divided sample and a full group sum both fit in 12 bits
    localparam int SUM_W  = 12;
    localparam int SHIFT  = 4;

    // clamp limits
    localparam logic signed [RAW_W-1:0] CLAMP_HI = 16'sd2047;
    localparam logic signed [RAW_W-1:0] CLAMP_LO = -16'sd2048;

    // group phase counter
    localparam int PH_W = $clog2(DECIMATION + 1);

    // fade position runs 0..FADE_LENGTH
    localparam int FP_W  = $clog2(FADE_LENGTH + 1);
    // ring pointer runs 0..FADE_LENGTH-1
    localparam int PTR_W = (FADE_LENGTH > 1) ? $clog2(FADE_LENGTH) : 1;
    // slot arithmetic needs room for up to 2*FADE_LENGTH-2
    localparam int SL_W  = FP_W + 1;

    // blend products: sample times an unsigned weight
    localparam int PROD_W = OUT_W + FP_W + 1;

    localparam logic signed [SUM_W-1:0]  DEC_S      = SUM_W'(DECIMATION);
    localparam logic signed [PROD_W-1:0] FADE_DIV_S = PROD_W'(FADE_DIV);

    // history entry: left in the low half, right in the high half
    localparam int HIST_W = 2 * OUT_W;

    // per-lane control from the top level
    typedef struct packed {
        logic            acc;     // input item accepted this cycle
        logic            seg;     // accepted item starts a segment
        logic            done;    // accepted item completes a group
        logic            load_c;  // blend stage takes new products
        logic            blend_b; // item in stage b is crossfaded
        logic [FP_W-1:0] w_hist;  // history weight N - i
        logic [FP_W-1:0] w_cur;   // current weight i + 1
    } t_lane_ctrl;

    // history ring access, issued at accept time
    typedef struct packed {
        logic            wr;      // capture the new output sample
        logic            rd;      // fetch the entry for the crossfade
        logic [FP_W-1:0] pos;     // fade position of this output
    } t_hist_req;

endpackage

// ----- rtl/decimate_and_crossfade_stereo_audio_core.sv -----
// decimate_and_crossfade_stereo_audio_core: top level, control, pipeline valids and output merge
// depends on dcf_pkg, dcf_lane and dcf_hist

// Stereo decimator with a segment-start crossfade. One raw stereo item is taken every
// clock cycle while not stalled; every DECIMATION items form one output item. The left
// and right lanes run side by side: clamp and divide, group sum, then a multiply stage
// and a divide-add stage. A completed group passes stage b with the registered history
// read, then the product and output registers. With fast_forward set, the first
// FADE_LENGTH outputs of a segment blend with the history ring, newest entry first;
// later outputs are stored into the ring, which reads as silence after reset. The user
// must write fast_forward only while the block is idle; the block does not enforce it.
module decimate_and_crossfade_stereo_audio_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data,
    // raw stereo input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [dcf_pkg::RAW_W-1:0]  i_left_raw,
    input  logic signed [dcf_pkg::RAW_W-1:0]  i_right_raw,
    input  logic                              i_segment_start,
    // decimated output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [dcf_pkg::OUT_W-1:0]  o_left_out,
    output logic signed [dcf_pkg::OUT_W-1:0]  o_right_out
);

    logic                          r_ff;
    logic [dcf_pkg::PH_W-1:0]      r_phase;
    logic [dcf_pkg::PH_W-1:0]      n_phase;
    logic [dcf_pkg::PH_W-1:0]      phase_base;
    logic [dcf_pkg::FP_W-1:0]      r_fpos;
    logic [dcf_pkg::FP_W-1:0]      n_fpos;
    logic [dcf_pkg::FP_W-1:0]      pos_cur;
    logic                          fading;
    logic                          in_acc;
    logic                          done;
    logic                          out_room;
    logic                          c_free;
    logic                          b_free;
    logic                          b_go;
    logic                          r_b_valid;
    logic                          r_b_blend;
    logic [dcf_pkg::FP_W-1:0]      r_b_pos;
    logic                          r_c_valid;
    logic                          r_o_valid;
    logic signed [dcf_pkg::OUT_W-1:0] r_o_left;
    logic signed [dcf_pkg::OUT_W-1:0] r_o_right;
    dcf_pkg::t_lane_ctrl           lane_ctrl;
    dcf_pkg::t_hist_req            hist_req;
    logic signed [dcf_pkg::OUT_W-1:0] samp_l;
    logic signed [dcf_pkg::OUT_W-1:0] samp_r;
    logic signed [dcf_pkg::OUT_W-1:0] res_l;
    logic signed [dcf_pkg::OUT_W-1:0] res_r;
    logic [dcf_pkg::HIST_W-1:0]    hist_rd;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff <= 1'b0;
        end else if (i_cfg_valid) begin
            r_ff <= i_cfg_data;
        end
    end

    // pipeline flow: each stage moves when the one after it can take its item
    assign out_room   = !r_o_valid || !i_out_stall;
    assign c_free     = !r_c_valid || out_room;
    assign b_free     = !r_b_valid || c_free;
    assign b_go       = r_b_valid && c_free;
    assign o_in_stall = !b_free;
    assign in_acc     = i_in_valid && b_free;

    // group phase and segment fade position
    assign phase_base = i_segment_start ? '0 : r_phase;
    assign done       = (phase_base == dcf_pkg::PH_W'(dcf_pkg::DECIMATION - 1));
    assign pos_cur    = i_segment_start ? '0 : r_fpos;
    assign fading     = (pos_cur < dcf_pkg::FP_W'(dcf_pkg::FADE_LENGTH));

    always_comb begin
        n_phase = r_phase;
        n_fpos  = r_fpos;
        if (in_acc) begin
            n_phase = done ? '0 : phase_base + 1'b1;
            n_fpos  = pos_cur;
            if (done && fading) begin
                n_fpos = pos_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_fpos  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fpos  <= n_fpos;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc && done) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
            if (out_room) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    // stage b side information
    always_ff @(posedge i_clk) begin
        if (in_acc && done) begin
            r_b_blend <= r_ff && fading;
            r_b_pos   <= pos_cur;
        end
    end

    // lane control
    always_comb begin
        lane_ctrl.acc     = in_acc;
        lane_ctrl.seg     = i_segment_start;
        lane_ctrl.done    = done;
        lane_ctrl.load_c  = c_free;
        lane_ctrl.blend_b = r_b_blend;
        lane_ctrl.w_hist  = dcf_pkg::FP_W'(dcf_pkg::FADE_LENGTH) - r_b_pos;
        lane_ctrl.w_cur   = r_b_pos + 1'b1;
    end

    // history access for the completed group
    always_comb begin
        hist_req.wr  = in_acc && done && r_ff && !fading;
        hist_req.rd  = in_acc && done && r_ff && fading;
        hist_req.pos = pos_cur;
    end

    dcf_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (lane_ctrl),
        .i_raw    (i_left_raw),
        .i_hist   (hist_rd[dcf_pkg::OUT_W-1:0]),
        .o_samp   (samp_l),
        .o_result (res_l)
    );

    dcf_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (lane_ctrl),
        .i_raw    (i_right_raw),
        .i_hist   (hist_rd[dcf_pkg::HIST_W-1:dcf_pkg::OUT_W]),
        .o_samp   (samp_r),
        .o_result (res_r)
    );

    dcf_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (hist_req),
        .i_wr_data ({samp_r, samp_l}),
        .o_rd_data (hist_rd)
    );

    // merge the lane results into the output register
    always_ff @(posedge i_clk) begin
        if (out_room) begin
            r_o_left  <= res_l;
            r_o_right <= res_r;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_left_out  = r_o_left;
    assign o_right_out = r_o_right;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < dcf_pkg::PH_W'(dcf_pkg::DECIMATION))
        else $error("group phase beyond decimation factor");

    a_group_to_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && done |=> r_b_valid)
        else $error("completed group did not reach stage b");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_out_stall |=> r_o_valid && $stable(r_o_left) && $stable(r_o_right))
        else $error("stalled output item lost or changed");

    a_fade_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fpos <= dcf_pkg::FP_W'(dcf_pkg::FADE_LENGTH))
        else $error("fade position beyond fade length");

endmodule

// ----- rtl/dcf_lane.sv -----
// dcf_lane: one audio channel: clamp, divide, group sum, then weighted crossfade
// depends on dcf_pkg
module dcf_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dcf_pkg::t_lane_ctrl                   i_ctrl,
    input  logic signed [dcf_pkg::RAW_W-1:0]      i_raw,
    input  logic signed [dcf_pkg::OUT_W-1:0]      i_hist,
    output logic signed [dcf_pkg::OUT_W-1:0]      o_samp,
    output logic signed [dcf_pkg::OUT_W-1:0]      o_result
);

    logic signed [dcf_pkg::SUM_W-1:0]  clamped;
    logic signed [dcf_pkg::SUM_W-1:0]  quo;
    logic signed [dcf_pkg::SUM_W-1:0]  sum_base;
    logic signed [dcf_pkg::SUM_W-1:0]  sum_new;
    logic signed [dcf_pkg::SUM_W-1:0]  r_sum;
    logic signed [dcf_pkg::SUM_W-1:0]  n_sum;
    logic signed [dcf_pkg::OUT_W-1:0]  r_b_cur;
    logic signed [dcf_pkg::PROD_W-1:0] prod_h;
    logic signed [dcf_pkg::PROD_W-1:0] prod_c;
    logic signed [dcf_pkg::PROD_W-1:0] r_c_ph;
    logic signed [dcf_pkg::PROD_W-1:0] r_c_pc;
    logic signed [dcf_pkg::OUT_W-1:0]  r_c_cur;
    logic                              r_c_blend;
    logic signed [dcf_pkg::PROD_W-1:0] mix;

    // clamp to 12 bits and divide, truncating toward zero
    always_comb begin
        if (i_raw > dcf_pkg::CLAMP_HI) begin
            clamped = dcf_pkg::SUM_W'(dcf_pkg::CLAMP_HI);
        end else if (i_raw < dcf_pkg::CLAMP_LO) begin
            clamped = dcf_pkg::SUM_W'(dcf_pkg::CLAMP_LO);
        end else begin
            clamped = dcf_pkg::SUM_W'(i_raw);
        end
        quo = clamped / dcf_pkg::DEC_S;
    end

    // group accumulation; a segment start drops a partial group
    assign sum_base = i_ctrl.seg ? '0 : r_sum;
    assign sum_new  = sum_base + quo;
    assign o_samp   = {sum_new, {dcf_pkg::SHIFT{1'b0}}};

    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.acc) begin
            n_sum = i_ctrl.done ? '0 : sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // stage b: finished group sample, history entry arrives alongside
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc && i_ctrl.done) begin
            r_b_cur <= o_samp;
        end
    end

    // weighted products of history and current sample
    assign prod_h = dcf_pkg::PROD_W'(i_hist) * $signed({1'b0, i_ctrl.w_hist});
    assign prod_c = dcf_pkg::PROD_W'(r_b_cur) * $signed({1'b0, i_ctrl.w_cur});

    // stage c: registered products
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_c) begin
            r_c_ph    <= prod_h;
            r_c_pc    <= prod_c;
            r_c_cur   <= r_b_cur;
            r_c_blend <= i_ctrl.blend_b;
        end
    end

    // each product divided with truncation toward zero, then summed
    assign mix      = (r_c_ph / dcf_pkg::FADE_DIV_S) + (r_c_pc / dcf_pkg::FADE_DIV_S);
    assign o_result = r_c_blend ? mix[dcf_pkg::OUT_W-1:0] : r_c_cur;

endmodule

// ----- rtl/dcf_hist.sv -----
// dcf_hist: history ring of recent stereo outputs with write pointer and read slot logic
// depends on dcf_pkg
module dcf_hist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dcf_pkg::t_hist_req                i_req,
    input  logic [dcf_pkg::HIST_W-1:0]        i_wr_data,
    output logic [dcf_pkg::HIST_W-1:0]        o_rd_data
);

    logic [dcf_pkg::HIST_W-1:0]      r_mem [dcf_pkg::FADE_LENGTH];
    logic [dcf_pkg::FADE_LENGTH-1:0] r_vld;
    logic [dcf_pkg::PTR_W-1:0]       r_wptr;
    logic [dcf_pkg::PTR_W-1:0]       n_wptr;
    logic [dcf_pkg::SL_W-1:0]        slot_raw;
    logic [dcf_pkg::PTR_W-1:0]       rd_addr;
    logic [dcf_pkg::HIST_W-1:0]      r_rd_data;
    logic                            r_rd_vld;

    // newest entry minus fade position, modulo ring depth
    always_comb begin
        slot_raw = dcf_pkg::SL_W'(r_wptr) + dcf_pkg::SL_W'(dcf_pkg::FADE_LENGTH - 1)
                   - dcf_pkg::SL_W'(i_req.pos);
        if (slot_raw >= dcf_pkg::SL_W'(dcf_pkg::FADE_LENGTH)) begin
            slot_raw = slot_raw - dcf_pkg::SL_W'(dcf_pkg::FADE_LENGTH);
        end
        rd_addr = slot_raw[dcf_pkg::PTR_W-1:0];
    end

    // write pointer wraps at the ring depth
    always_comb begin
        n_wptr = r_wptr;
        if (i_req.wr) begin
            if (r_wptr == dcf_pkg::PTR_W'(dcf_pkg::FADE_LENGTH - 1)) begin
                n_wptr = '0;
            end else begin
                n_wptr = r_wptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_vld  <= '0;
        end else begin
            r_wptr <= n_wptr;
            if (i_req.wr) begin
                r_vld[r_wptr] <= 1'b1;
            end
        end
    end

    // ring storage, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    // unwritten entries read as silence
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr < dcf_pkg::PTR_W'(dcf_pkg::FADE_LENGTH))
        else $error("history write pointer beyond ring depth");

    a_wr_rd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.wr && i_req.rd))
        else $error("history written and read for the same item");

    a_wr_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr |=> r_vld[$past(r_wptr)])
        else $error("written history entry not marked valid");

endmodule
